@@ hdl/bia_pkg.sv @@
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types, status codes and the pool base table of the ID allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EXHAUSTED = 2'd1;
   localparam status_type ST_BAD_ID    = 2'd2;
   localparam status_type ST_BAD_POOL  = 2'd3;

   localparam int WORD_BITS = 64;

   // controller to datapath
   typedef struct packed {
      logic       clr_step;   // write one zero word of the clearing pass
      logic       take_req;   // capture the request beat
      logic       check;      // derive word and bit from the request
      logic       mem_rd;     // read the current bitmap word
      logic       word_inc;   // advance to the next word of the pool
      logic       mem_write;  // write back the updated word
      logic       res_load;   // capture the result with res_code
      status_type res_code;
      logic       out_load;   // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic op_alloc;
      logic bad_pool;
      logic range_bad;
      logic found;
      logic bit_set;
      logic last_word;
      logic out_free;
   } stat_type;

   function automatic logic [31:0] pool_base(input logic [4:0] pool);
      logic [31:0] base;
      case (pool)
         5'd0:    base = 32'h1000_0000;
         5'd1:    base = 32'h2000_0000;
         5'd2:    base = 32'h3000_0000;
         5'd3:    base = 32'h4000_0000;
         5'd4:    base = 32'h5000_0000;
         5'd5:    base = 32'h6000_0000;
         5'd6:    base = 32'h7000_0000;
         5'd7:    base = 32'h8000_0000;
         5'd8:    base = 32'h9000_0000;
         5'd9:    base = 32'ha000_0000;
         5'd10:   base = 32'hb000_0000;
         5'd11:   base = 32'hc000_0000;
         5'd12:   base = 32'hd000_0000;
         5'd13:   base = 32'he000_0000;
         5'd14:   base = 32'hf000_0000;
         5'd15:   base = 32'h1100_0000;
         5'd16:   base = 32'h1200_0000;
         5'd17:   base = 32'h1400_0000;
         5'd18:   base = 32'h1500_0000;
         5'd19:   base = 32'h1600_0000;
         default: base = 32'h0000_0000;
      endcase
      return base;
   endfunction

endpackage

@@ hdl/bia_if.sv @@
// ----------------------------------------------------------------------------
// bia_if
// Request and response channels of the ID allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bia_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [4:0]  pool;
   logic [31:0] id_value;

   modport source (output valid, output op, output pool, output id_value, input ready);
   modport sink   (input valid, input op, input pool, input id_value, output ready);
endinterface

interface bia_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] new_id;
   logic [7:0]  slot;

   modport source (output valid, output status, output new_id, output slot, input ready);
   modport sink   (input valid, input status, input new_id, input slot, output ready);
endinterface

@@ hdl/bitmap_id_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_id_allocator_top
// Multi-pool ID allocator over per-pool use bitmaps.
//
// A request beat on req_if asks to allocate the lowest free ID of a pool
// (op 0) or to free id_value in it (op 1). Each request gives exactly one
// response beat on rsp_if: status, new_id (base plus index on an allocate)
// and slot (index within the pool).
// One request is in work at a time; the next is taken once the result has
// moved to the output register. A bad pool or an out-of-range free goes from
// the check straight to the last step, a free reads one bitmap word, and an
// allocate reads its pool's words in turn until one has a free bit or it
// reaches the last (up to ceil(IDS_PER_POOL/64), 4 by default); the bitmap
// memory gives one 64-bit word per read; each costs a read and an evaluate step.
// After reset a clearing pass writes zero to all POOL_COUNT*ceil(IDS/64)
// words, one per cycle (80 words by default); req_if.ready stays low.
// The response sits in an output register: a stalled receiver holds it while
// the next request is accepted and worked on, which then waits in its last
// step until the register is free.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_top
   import bia_pkg::*;
#(
   parameter int POOL_COUNT   = 20,
   parameter int IDS_PER_POOL = 256
) (
   input  logic     clock,
   input  logic     reset,
   bia_req_if.sink   req_if,
   bia_rsp_if.source rsp_if
);

   cmd_type  cmd;
   stat_type stat;

   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bia_datapath #(
      .POOL_COUNT   (POOL_COUNT),
      .IDS_PER_POOL (IDS_PER_POOL)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_if.op),
      .req_pool     (req_if.pool),
      .req_id_value (req_if.id_value),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_status   (rsp_if.status),
      .rsp_new_id   (rsp_if.new_id),
      .rsp_slot     (rsp_if.slot)
   );

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while previous one in work");

   a_write_port : assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && cmd.mem_write))
      else $error("clearing pass and write-back collide");

   a_out_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("response overwritten before it was taken");

   a_clear_after_reset : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_if.ready)
      else $error("request accepted before clearing pass");

endmodule

@@ hdl/bia_ctrl.sv @@
// ----------------------------------------------------------------------------
// bia_ctrl
// Sequencer of the ID allocator: clearing pass, request check, word scan,
// write-back and hand-over to the output register.
// ----------------------------------------------------------------------------
module bia_ctrl
   import bia_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_code = ST_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.bad_pool) begin
               cmd.res_load = 1'b1;
               cmd.res_code = ST_BAD_POOL;
               state_in     = S_DONE;
            end else if (!stat.op_alloc && stat.range_bad) begin
               cmd.res_load = 1'b1;
               cmd.res_code = ST_BAD_ID;
               state_in     = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            if (stat.op_alloc) begin
               if (stat.found) begin
                  cmd.mem_write = 1'b1;
                  cmd.res_load  = 1'b1;
                  cmd.res_code  = ST_OK;
                  state_in      = S_DONE;
               end else if (stat.last_word) begin
                  cmd.res_load = 1'b1;
                  cmd.res_code = ST_EXHAUSTED;
                  state_in     = S_DONE;
               end else begin
                  cmd.word_inc = 1'b1;
                  state_in     = S_READ;
               end
            end else begin
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
               if (stat.bit_set) begin
                  cmd.mem_write = 1'b1;
                  cmd.res_code  = ST_OK;
               end else begin
                  cmd.res_code = ST_BAD_ID;
               end
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

@@ hdl/bia_datapath.sv @@
// ----------------------------------------------------------------------------
// bia_datapath
// Bitmap memory, request registers, free-bit search, result and output
// registers of the ID allocator.
// ----------------------------------------------------------------------------
module bia_datapath
   import bia_pkg::*;
#(
   parameter int POOL_COUNT   = 20,
   parameter int IDS_PER_POOL = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_op,
   input  logic [4:0]  req_pool,
   input  logic [31:0] req_id_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_new_id,
   output logic [7:0]  rsp_slot
);

   localparam int WPP          = (IDS_PER_POOL + WORD_BITS - 1) / WORD_BITS;
   localparam int BITMAP_WORDS = POOL_COUNT * WPP;
   localparam int AW           = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int WW           = (WPP > 1) ? $clog2(WPP) : 1;
   localparam int XW           = WW + 6;
   localparam int LAST_BITS    = IDS_PER_POOL - (WPP - 1) * WORD_BITS;
   localparam logic [63:0] LAST_MASK =
      (LAST_BITS == WORD_BITS) ? {64{1'b1}} : ((64'd1 << LAST_BITS) - 64'd1);

   logic [63:0] mem [BITMAP_WORDS];

   logic [AW-1:0] clr_cnt_ff;
   logic          op_ff;
   logic [4:0]    pool_ff;
   logic [31:0]   id_ff;
   logic [WW-1:0] word_ff;
   logic [5:0]    bit_ff;
   logic [63:0]   rd_data_ff;
   status_type    res_status_ff;
   logic [31:0]   res_new_id_ff;
   logic [7:0]    res_slot_ff;
   logic          out_valid_ff;
   status_type    out_status_ff;
   logic [31:0]   out_new_id_ff;
   logic [7:0]    out_slot_ff;

   logic [31:0]   base;
   logic [31:0]   idx32;
   logic [AW-1:0] addr;
   logic          last_word;
   logic [63:0]   masked;
   logic [63:0]   inv;
   logic [63:0]   lowest;
   logic [5:0]    found_bit;
   logic [5:0]    sel_bit;
   logic [XW-1:0] index;
   logic [63:0]   wr_data;

   assign base      = pool_base(pool_ff);
   assign idx32     = id_ff - base;
   assign addr      = AW'(32'(pool_ff) * 32'(WPP) + 32'(word_ff));
   assign last_word = (word_ff == WW'(WPP - 1));

   // bits past the pool size in its last word count as taken
   assign masked = rd_data_ff | (last_word ? ~LAST_MASK : 64'd0);
   assign inv    = ~masked;
   assign lowest = inv & (~inv + 64'd1);

   always_comb begin
      found_bit = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) found_bit = found_bit | 6'(i);
      end
   end

   assign sel_bit = op_ff ? bit_ff : found_bit;
   assign index   = {word_ff, sel_bit};
   assign wr_data = op_ff ? (rd_data_ff & ~(64'd1 << bit_ff)) : (rd_data_ff | lowest);

   assign stat.clr_last  = (clr_cnt_ff == AW'(BITMAP_WORDS - 1));
   assign stat.op_alloc  = !op_ff;
   assign stat.bad_pool  = ({1'b0, pool_ff} >= 6'(POOL_COUNT));
   assign stat.range_bad = (idx32 >= 32'(IDS_PER_POOL));
   assign stat.found     = |inv;
   assign stat.bit_set   = rd_data_ff[bit_ff];
   assign stat.last_word = last_word;
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   // bitmap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_cnt_ff] <= 64'd0;
      end else if (cmd.mem_write) begin
         mem[addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         op_ff   <= req_op;
         pool_ff <= req_pool;
         id_ff   <= req_id_value;
      end
      if (cmd.check) begin
         word_ff <= op_ff ? idx32[WW+5:6] : '0;
         bit_ff  <= idx32[5:0];
      end else if (cmd.word_inc) begin
         word_ff <= word_ff + WW'(1);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_code;
         res_new_id_ff <= (cmd.res_code == ST_OK && !op_ff) ? base + 32'(index) : 32'd0;
         res_slot_ff   <= (cmd.res_code == ST_OK) ? 8'(index) : 8'd0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_new_id_ff <= res_new_id_ff;
         out_slot_ff   <= res_slot_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_new_id = out_new_id_ff;
   assign rsp_slot   = out_slot_ff;

endmodule
